/* hdl/vcb_pkg.sv */
`timescale 1ns / 1ps

package vcb_pkg;

  // component width; magnitudes need the same width unsigned
  localparam int COORD_WIDTH = 16;
  localparam int MAG_W       = COORD_WIDTH;
  localparam int BEARING_W   = 9;

  // sin/cos table format and search geometry
  localparam int FRAC_W    = 62;
  localparam int HALF_W    = FRAC_W / 2;
  localparam int CNT_W     = 6;
  localparam int NSTEP     = CNT_W;
  localparam int TAB_DEPTH = 2 ** CNT_W;
  localparam int KMAX      = 44;
  localparam int PROD_W    = MAG_W + HALF_W;
  localparam int CMP_W     = MAG_W + FRAC_W;

  // front stage, two stages per search step, output stage
  localparam int NSTAGE = 2 * NSTEP + 2;

  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  localparam logic [CNT_W-1:0]     KMAX_C   = CNT_W'(KMAX);
  localparam logic [BEARING_W-1:0] DEG_0    = BEARING_W'(0);
  localparam logic [BEARING_W-1:0] DEG_45   = BEARING_W'(45);
  localparam logic [BEARING_W-1:0] DEG_89   = BEARING_W'(89);
  localparam logic [BEARING_W-1:0] DEG_90   = BEARING_W'(90);
  localparam logic [BEARING_W-1:0] DEG_180  = BEARING_W'(180);
  localparam logic [BEARING_W-1:0] DEG_270  = BEARING_W'(270);
  localparam logic [BEARING_W-1:0] DEG_FULL = BEARING_W'(360);

  typedef logic [TAB_DEPTH-1:0][FRAC_W-1:0] trig_tab_t;

  // one item in flight: smaller and larger magnitude, search accumulator
  typedef struct packed {
    logic [MAG_W-1:0]     num_m;
    logic [MAG_W-1:0]     den_m;
    logic [CNT_W-1:0]     acc;
    logic [BEARING_W-1:0] base;
    logic                 swap;
    logic                 eq;
    logic                 axis;
  } item_t;

  // partial products of one search step
  typedef struct packed {
    item_t             item;
    logic [PROD_W-1:0] nc_hi;
    logic [PROD_W-1:0] nc_lo;
    logic [PROD_W-1:0] ds_hi;
    logic [PROD_W-1:0] ds_lo;
    logic [CNT_W-1:0]  cand;
    logic              cand_ok;
  } prod_t;

  // truncated q2.62 product
  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // one degree in radians and its square
  localparam logic [63:0] RAD1_Q62 = PI_Q62 / 64'd180;
  localparam logic [63:0] RAD2_Q62 = qmul(RAD1_Q62, RAD1_Q62);

  // taylor terms of sin and cos of one degree
  localparam logic [63:0] TS1 = qmul(RAD1_Q62, RAD2_Q62) / 64'd6;
  localparam logic [63:0] TS2 = qmul(TS1, RAD2_Q62) / 64'd20;
  localparam logic [63:0] TS3 = qmul(TS2, RAD2_Q62) / 64'd42;
  localparam logic [63:0] TS4 = qmul(TS3, RAD2_Q62) / 64'd72;
  localparam logic [63:0] TS5 = qmul(TS4, RAD2_Q62) / 64'd110;
  localparam logic [63:0] TS6 = qmul(TS5, RAD2_Q62) / 64'd156;
  localparam logic [63:0] TS7 = qmul(TS6, RAD2_Q62) / 64'd210;
  localparam logic [63:0] TC1 = qmul(ONE_Q62, RAD2_Q62) / 64'd2;
  localparam logic [63:0] TC2 = qmul(TC1, RAD2_Q62) / 64'd12;
  localparam logic [63:0] TC3 = qmul(TC2, RAD2_Q62) / 64'd30;
  localparam logic [63:0] TC4 = qmul(TC3, RAD2_Q62) / 64'd56;
  localparam logic [63:0] TC5 = qmul(TC4, RAD2_Q62) / 64'd90;
  localparam logic [63:0] TC6 = qmul(TC5, RAD2_Q62) / 64'd132;
  localparam logic [63:0] TC7 = qmul(TC6, RAD2_Q62) / 64'd182;

  localparam logic [63:0] SIN1_Q62 = RAD1_Q62 - TS1 + TS2 - TS3 + TS4 - TS5 + TS6 - TS7;
  localparam logic [63:0] COS1_Q62 = ONE_Q62 - TC1 + TC2 - TC3 + TC4 - TC5 + TC6 - TC7;

  // sin or cos of k degrees for k = 1..44, built at elaboration
  function automatic trig_tab_t trig_table(input logic want_sin);
    trig_tab_t   tab;
    logic [63:0] s, c, nc, ns;
    tab = '0;
    s   = SIN1_Q62;
    c   = COS1_Q62;
    for (int k = 1; k <= KMAX; k++) begin
      tab[CNT_W'(k)] = want_sin ? s[FRAC_W-1:0] : c[FRAC_W-1:0];
      nc = qmul(c, COS1_Q62) - qmul(s, SIN1_Q62);
      ns = qmul(s, COS1_Q62) + qmul(c, SIN1_Q62);
      c  = nc;
      s  = ns;
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = trig_table(1'b0);
  localparam trig_tab_t SIN_TAB = trig_table(1'b1);

endpackage

/* hdl/vcb_search_step.sv */
`timescale 1ns / 1ps

// one bit of the degree search: products, then compare and keep
module vcb_search_step (
  input  logic               clk,
  input  logic               en_a,
  input  logic               en_b,
  input  logic [vcb_pkg::CNT_W-1:0] step_bit,
  input  vcb_pkg::item_t     item_in,
  output vcb_pkg::item_t     item_out
);

  vcb_pkg::prod_t prod_nxt, prod_r;
  vcb_pkg::item_t item_nxt, item_r;

  logic [vcb_pkg::FRAC_W-1:0] cos_k, sin_k;
  logic [vcb_pkg::CMP_W-1:0]  lhs, rhs;

  always_comb begin
    prod_nxt.item    = item_in;
    prod_nxt.cand    = item_in.acc | step_bit;
    prod_nxt.cand_ok = (prod_nxt.cand <= vcb_pkg::KMAX_C);
    cos_k = vcb_pkg::COS_TAB[prod_nxt.cand];
    sin_k = vcb_pkg::SIN_TAB[prod_nxt.cand];
    prod_nxt.nc_hi = {{vcb_pkg::HALF_W{1'b0}}, item_in.num_m}
                   * {{vcb_pkg::MAG_W{1'b0}}, cos_k[vcb_pkg::FRAC_W-1:vcb_pkg::HALF_W]};
    prod_nxt.nc_lo = {{vcb_pkg::HALF_W{1'b0}}, item_in.num_m}
                   * {{vcb_pkg::MAG_W{1'b0}}, cos_k[vcb_pkg::HALF_W-1:0]};
    prod_nxt.ds_hi = {{vcb_pkg::HALF_W{1'b0}}, item_in.den_m}
                   * {{vcb_pkg::MAG_W{1'b0}}, sin_k[vcb_pkg::FRAC_W-1:vcb_pkg::HALF_W]};
    prod_nxt.ds_lo = {{vcb_pkg::HALF_W{1'b0}}, item_in.den_m}
                   * {{vcb_pkg::MAG_W{1'b0}}, sin_k[vcb_pkg::HALF_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    lhs = (vcb_pkg::CMP_W'(prod_r.nc_hi) << vcb_pkg::HALF_W) + vcb_pkg::CMP_W'(prod_r.nc_lo);
    rhs = (vcb_pkg::CMP_W'(prod_r.ds_hi) << vcb_pkg::HALF_W) + vcb_pkg::CMP_W'(prod_r.ds_lo);
    item_nxt = prod_r.item;
    if (prod_r.cand_ok && (lhs >= rhs)) begin
      item_nxt.acc = prod_r.cand;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

/* hdl/vector_compass_bearing.sv */
`timescale 1ns / 1ps

// channel | direction | ports
// --------+-----------+---------------------------------------------------
// in      | input     | in_valid, in_stall, in_right_part, in_down_part
// out     | output    | out_valid, out_stall, out_bearing_deg
//
// one item per cycle while out_stall is low; every item passes 14 register
// stages in order: a front stage, six search steps of two stages each, an
// output stage
// each search step tests one bit of the degree count against the sin/cos
// table in 31-bit halves of each 62-bit entry, then compares and keeps the bit
// reset clears only the stage valid bits; payload registers are not reset
// stages stall independently, so empty slots fill while a result waits

module vector_compass_bearing (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [vcb_pkg::COORD_WIDTH-1:0] in_right_part,
  input  logic signed [vcb_pkg::COORD_WIDTH-1:0] in_down_part,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vcb_pkg::BEARING_W-1:0]      out_bearing_deg
);

  localparam int LAST = vcb_pkg::NSTAGE - 1;
  localparam int W    = vcb_pkg::COORD_WIDTH;

  // per-stage valid bits and load enables
  logic [LAST:0] vld_r, vld_nxt;
  logic [LAST:0] en;

  // item between search steps; entry zero is the front register
  vcb_pkg::item_t stage_item [vcb_pkg::NSTEP+1];
  vcb_pkg::item_t front_nxt, front_r;

  logic [vcb_pkg::BEARING_W-1:0] bearing_nxt, bearing_r;

  // front stage signals
  logic [W-1:0] r_u, d_u, rm, dm, num_q, den_q;
  logic         rneg, dneg, r_zero, d_zero;

  // a stage loads when empty or when the one after it moves on
  always_comb begin
    en[LAST] = !vld_r[LAST] || !out_stall;
    for (int s = LAST - 1; s >= 0; s--) begin
      en[s] = !vld_r[s] || en[s+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int s = 1; s <= LAST; s++) begin
      if (en[s]) begin
        vld_nxt[s] = vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // front: magnitudes, quadrant base, axis cases, smaller over larger
  always_comb begin
    r_u    = $unsigned(in_right_part);
    d_u    = $unsigned(in_down_part);
    rneg   = r_u[W-1];
    dneg   = d_u[W-1];
    // most negative value negates to itself, which is the right magnitude
    rm     = rneg ? (~r_u + W'(1)) : r_u;
    dm     = dneg ? (~d_u + W'(1)) : d_u;
    r_zero = (r_u == '0);
    d_zero = (d_u == '0);

    front_nxt      = '0;
    front_nxt.axis = r_zero || d_zero;
    num_q          = rm;
    den_q          = dm;
    if (r_zero) begin
      // straight up and the zero vector both give zero
      front_nxt.base = (!d_zero && !dneg) ? vcb_pkg::DEG_180 : vcb_pkg::DEG_0;
    end else if (d_zero) begin
      front_nxt.base = rneg ? vcb_pkg::DEG_270 : vcb_pkg::DEG_90;
    end else if (!rneg && dneg) begin
      front_nxt.base = vcb_pkg::DEG_0;
    end else if (!rneg && !dneg) begin
      front_nxt.base = vcb_pkg::DEG_90;
      num_q          = dm;
      den_q          = rm;
    end else if (rneg && !dneg) begin
      front_nxt.base = vcb_pkg::DEG_180;
    end else begin
      front_nxt.base = vcb_pkg::DEG_270;
      num_q          = dm;
      den_q          = rm;
    end

    // search always runs on ratio at most one; above one mirrors about 45
    front_nxt.eq    = (num_q == den_q);
    front_nxt.swap  = (num_q > den_q);
    front_nxt.num_m = front_nxt.swap ? den_q : num_q;
    front_nxt.den_m = front_nxt.swap ? num_q : den_q;
    front_nxt.acc   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      front_r <= front_nxt;
    end
  end

  assign stage_item[0] = front_r;

  // binary search for the degree count, most significant bit first
  for (genvar i = 0; i < vcb_pkg::NSTEP; i++) begin : g_step
    vcb_search_step u_step (
      .clk      (clk),
      .en_a     (en[1 + 2 * i]),
      .en_b     (en[2 + 2 * i]),
      .step_bit (vcb_pkg::CNT_W'(1 << (vcb_pkg::NSTEP - 1 - i))),
      .item_in  (stage_item[i]),
      .item_out (stage_item[i+1])
    );
  end

  // output: equal magnitudes give 45, mirrored ratios give 89 minus count
  always_comb begin
    vcb_pkg::item_t fin;
    logic [vcb_pkg::BEARING_W-1:0] ang;
    fin = stage_item[vcb_pkg::NSTEP];
    if (fin.eq) begin
      ang = vcb_pkg::DEG_45;
    end else if (fin.swap) begin
      ang = vcb_pkg::DEG_89 - vcb_pkg::BEARING_W'(fin.acc);
    end else begin
      ang = vcb_pkg::BEARING_W'(fin.acc);
    end
    bearing_nxt = fin.axis ? fin.base : (fin.base + ang);
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      bearing_r <= bearing_nxt;
    end
  end

  assign out_valid       = vld_r[LAST];
  assign out_bearing_deg = bearing_r;

`ifndef SYNTHESIS
  // a bearing never reaches a full turn
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bearing_deg < vcb_pkg::DEG_FULL))
    else $error("bearing out of range");

  // an empty front stage always takes an item
  a_front_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> !in_stall)
    else $error("input stalled with empty front stage");

  // a delivered result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !vld_r[LAST-1]) |=> !out_valid)
    else $error("result repeated after delivery");

  // input stall implies every stage holds an item and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled with a free slot");
`endif

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int CW        = vcb_pkg::COORD_WIDTH;
  localparam int BEARING_W = vcb_pkg::BEARING_W;
  localparam int KMAX      = vcb_pkg::KMAX;
  localparam int MAX_MAG   = 2 ** (CW - 1);
  localparam int TAIL_CYC  = 40;

  // one vector waiting to be offered to the block
  typedef struct packed {
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] down;
  } vec_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [CW-1:0] in_right_part = '0;
  logic signed [CW-1:0] in_down_part = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BEARING_W-1:0] out_bearing_deg;

  // sin/cos of whole degrees 1..44 in q2.62, built once at time zero
  logic [63:0] sin_q62 [1:KMAX];
  logic [63:0] cos_q62 [1:KMAX];

  vec_t                 pending_vecs[$];
  logic [BEARING_W-1:0] expected_bearings[$];

  int unsigned total_vecs = 0;
  int unsigned sent_count = 0;
  int unsigned mismatches = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          drv_calm = 1'b0;
  bit          mon_calm = 1'b0;

  vector_compass_bearing u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_right_part   (in_right_part),
    .in_down_part    (in_down_part),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bearing_deg (out_bearing_deg)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // truncated q2.62 multiply
  function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // taylor series for one degree, then repeated rotation by one degree
  task automatic build_trig();
    logic [63:0] x, x2, s1, c1, ts, tc, s, c, nc;
    x  = vcb_pkg::PI_Q62 / 64'd180;
    x2 = fix_mul(x, x);
    s1 = x;
    c1 = vcb_pkg::ONE_Q62;
    ts = x;
    tc = vcb_pkg::ONE_Q62;
    for (int n = 1; n <= 7; n++) begin
      ts = fix_mul(ts, x2) / 64'((2 * n) * (2 * n + 1));
      tc = fix_mul(tc, x2) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s1 = s1 - ts;
        c1 = c1 - tc;
      end else begin
        s1 = s1 + ts;
        c1 = c1 + tc;
      end
    end
    s = s1;
    c = c1;
    for (int k = 1; k <= KMAX; k++) begin
      sin_q62[k] = s;
      cos_q62[k] = c;
      nc = fix_mul(c, c1) - fix_mul(s, s1);
      s  = fix_mul(s, c1) + fix_mul(c, s1);
      c  = nc;
    end
  endtask

  // whole degrees k in 1..44 where num*cos(k) >= den*sin(k), stopping at first miss
  function automatic int unsigned whole_deg_below(input logic [63:0] num,
                                                  input logic [63:0] den);
    logic [127:0] lhs, rhs;
    int unsigned  cnt;
    bit           stop;
    cnt  = 0;
    stop = 1'b0;
    for (int k = 1; k <= KMAX; k++) begin
      lhs = {64'd0, num} * {64'd0, cos_q62[k]};
      rhs = {64'd0, den} * {64'd0, sin_q62[k]};
      if (!stop && lhs >= rhs) cnt = k;
      else stop = 1'b1;
    end
    return cnt;
  endfunction

  // truncated atan(num/den) in degrees, both magnitudes positive
  function automatic int unsigned atan_whole_deg(input logic [63:0] num,
                                                 input logic [63:0] den);
    if (num == den) return 45;
    if (num < den) return whole_deg_below(num, den);
    return 89 - whole_deg_below(den, num);
  endfunction

  // compass bearing clockwise from up; axes and the zero vector are fixed
  function automatic logic [BEARING_W-1:0] bearing_of(input logic signed [CW-1:0] r,
                                                      input logic signed [CW-1:0] d);
    int          ri, di;
    logic [63:0] rm, dm;
    int unsigned b;
    ri = r;
    di = d;
    rm = 64'(ri < 0 ? -ri : ri);
    dm = 64'(di < 0 ? -di : di);
    if (ri == 0) b = (di > 0) ? 180 : 0;
    else if (di == 0) b = (ri < 0) ? 270 : 90;
    else if (ri > 0 && di < 0) b = atan_whole_deg(rm, dm);
    else if (ri > 0) b = 90 + atan_whole_deg(dm, rm);
    else if (di > 0) b = 180 + atan_whole_deg(rm, dm);
    else b = 270 + atan_whole_deg(dm, rm);
    return BEARING_W'(b);
  endfunction

  task automatic queue_vec(input int r, input int d);
    vec_t v;
    v.right = CW'(r);
    v.down  = CW'(d);
    pending_vecs.push_back(v);
  endtask

  // idle length for either side: mostly none or short, now and then long
  function automatic int unsigned idle_len(input bit calm);
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pick a component from the extreme corner values
  function automatic int corner_val();
    case ($urandom_range(0, 6))
      0: return -MAX_MAG;
      1: return -MAX_MAG + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return MAX_MAG - 2;
      default: return MAX_MAG - 1;
    endcase
  endfunction

  // random vectors, weighted toward degree boundaries and the special cases
  task automatic queue_random(input int unsigned count);
    int           a, b, r, d, k, sel, tmp;
    logic [127:0] t;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        // ratio right at tan(k deg), off by at most one lsb
        b = $urandom_range(1, MAX_MAG - 1);
        k = $urandom_range(1, KMAX);
        t = ({64'd0, 64'(b)} * {64'd0, sin_q62[k]}) / {64'd0, cos_q62[k]};
        a = int'(t[31:0]) + $urandom_range(0, 2) - 1;
        if (a < 1) a = 1;
        if (a > b) a = b;
        if ($urandom_range(0, 1) == 1) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
        r = $urandom_range(0, 1) ? -a : a;
        d = $urandom_range(0, 1) ? -b : b;
      end else if (sel < 65) begin
        r = $signed(CW'($urandom));
        d = $signed(CW'($urandom));
      end else if (sel < 80) begin
        r = $urandom_range(0, 16) - 8;
        d = $urandom_range(0, 16) - 8;
      end else if (sel < 88) begin
        // on an axis, or the zero vector
        a = $signed(CW'($urandom));
        if ($urandom_range(0, 1) == 1) begin
          r = a;
          d = 0;
        end else begin
          r = 0;
          d = a;
        end
      end else if (sel < 94) begin
        // equal magnitudes, including the most negative value
        a = $urandom_range(1, MAX_MAG);
        r = $urandom_range(0, 1) ? -a : a;
        d = $urandom_range(0, 1) ? -a : a;
        if (r == MAX_MAG) r = -MAX_MAG;
        if (d == MAX_MAG) d = -MAX_MAG;
      end else begin
        r = corner_val();
        d = corner_val();
      end
      queue_vec(r, d);
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    build_trig();

    // directed: axes, zero vector, equal magnitudes, most negative values
    queue_vec(0, 0);
    queue_vec(0, -1);
    queue_vec(0, -MAX_MAG);
    queue_vec(1, 0);
    queue_vec(MAX_MAG - 1, 0);
    queue_vec(0, 1);
    queue_vec(0, MAX_MAG - 1);
    queue_vec(-1, 0);
    queue_vec(-MAX_MAG, 0);
    queue_vec(7, -7);
    queue_vec(9, 9);
    queue_vec(-3, 3);
    queue_vec(-MAX_MAG, -MAX_MAG);
    queue_vec(MAX_MAG - 1, MAX_MAG - 1);
    queue_vec(-MAX_MAG, MAX_MAG - 1);
    queue_vec(MAX_MAG - 1, -MAX_MAG);
    queue_vec(1, -(MAX_MAG - 1));
    queue_vec(MAX_MAG - 1, -1);
    queue_vec(-MAX_MAG, 1);
    queue_vec(1, MAX_MAG - 1);
    queue_vec(-1, -MAX_MAG);
    queue_vec(-(MAX_MAG - 1), -MAX_MAG);
    queue_vec(2, -1);
    queue_vec(-1, 2);

    queue_random(1850);
    total_vecs = pending_vecs.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // sample away from the rising edge so the counters have settled
    while (sent_count < total_vecs) @(negedge clk);
    while (expected_bearings.size() != 0) @(negedge clk);
    // a little longer to catch any stray result
    repeat (TAIL_CYC) @(negedge clk);

    if (mismatches == 0 && expected_bearings.size() == 0) begin
      $display("vector_compass_bearing: match");
    end else begin
      $display("vector_compass_bearing: mismatch");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("vector_compass_bearing: mismatch");
    $finish;
  end

  // driver: offers the next pending vector, with random gaps between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // item taken on this edge: its expected bearing joins the queue
      if (in_valid && !in_stall) begin
        expected_bearings.push_back(bearing_of(in_right_part, in_down_part));
        sent_count++;
      end
      // payload only moves once the current item is gone
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_vecs.size() > 0) begin
          in_valid      <= 1'b1;
          in_right_part <= pending_vecs[0].right;
          in_down_part  <= pending_vecs[0].down;
          void'(pending_vecs.pop_front());
          // switch in and out of gap-free bursts now and then
          if ($urandom_range(0, 149) == 0) drv_calm = !drv_calm;
          gap_left = idle_len(drv_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, check each taken result against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bearings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: bearing %0d", out_bearing_deg);
        end else begin
          if (out_bearing_deg !== expected_bearings[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("bearing wrong: expected %0d, got %0d",
                       expected_bearings[0], out_bearing_deg);
          end
          void'(expected_bearings.pop_front());
        end
      end
      // stall runs of random length, with quiet stretches between
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 299) == 0) mon_calm = !mon_calm;
        stall_left = idle_len(mon_calm);
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

endmodule
